### rtl/base64_encoder_unit_defines.svh
// Assertion macros used by the checker file of the base64 encoder.
`ifndef BASE64_ENCODER_UNIT_DEFINES_SVH
`define BASE64_ENCODER_UNIT_DEFINES_SVH

// Clocked check, off while reset is asserted.
`define BENC_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds while reset is asserted.
`define BENC_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/benc_pkg.sv
// Package of the base64 encoder: group type, pad codes and alphabet lookup.
package benc_pkg;

	// number of '=' characters that close a group
	typedef enum logic [1:0] {
		PAD_NONE = 2'd0,
		PAD_ONE  = 2'd1,
		PAD_TWO  = 2'd2
	} pad_t;

	// character slot inside a group of four
	typedef enum logic [1:0] {
		SLOT_0 = 2'd0,
		SLOT_1 = 2'd1,
		SLOT_2 = 2'd2,
		SLOT_3 = 2'd3
	} slot_t;

	// one group of up to three bytes, as queued between front and back
	typedef struct packed {
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		pad_t       pad;
		logic       last;
	} grp_t;

	localparam int unsigned QDEPTH = 2;
	localparam logic [7:0]  CHAR_PAD = 8'h3D;

	// RFC 4648 standard alphabet
	function automatic logic [7:0] sym(input logic [5:0] v);
		logic [7:0] w;
		w = {2'b00, v};
		if (v < 6'd26)      sym = 8'(8'd65 + w);
		else if (v < 6'd52) sym = 8'(8'd71 + w);
		else if (v < 6'd62) sym = 8'(w - 8'd4);
		else if (v == 6'd62) sym = 8'h2B;
		else                sym = 8'h2F;
	endfunction

endpackage

### rtl/benc_if.sv
// Channel interfaces of the base64 encoder: raw byte input and character output.
interface benc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_message;

	modport source (output valid, output data_byte, output end_of_message, input ready);
	modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface benc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       out_last;

	modport source (output valid, output out_char, output out_last, input ready);
	modport sink   (input valid, input out_char, input out_last, output ready);
endinterface

### rtl/benc_front.sv
// Front of the encoder: collects bytes into groups and pushes closed groups.
module benc_front import benc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       end_of_message,
	output logic       push,
	output grp_t       push_grp,
	input  logic       q_full
);

	logic [7:0] hold0_q;
	logic [7:0] hold1_q;
	logic [1:0] pos_q;
	logic       take;

	assign in_ready = !q_full;
	assign take     = in_valid && !q_full;

	always_comb begin
		push          = 1'b0;
		push_grp.b0   = data_byte;
		push_grp.b1   = 8'd0;
		push_grp.b2   = 8'd0;
		push_grp.pad  = PAD_TWO;
		push_grp.last = 1'b1;
		case (pos_q)
			2'd1: begin
				push_grp.b0  = hold0_q;
				push_grp.b1  = data_byte;
				push_grp.pad = PAD_ONE;
				push         = take && end_of_message;
			end
			2'd2: begin
				push_grp.b0   = hold0_q;
				push_grp.b1   = hold1_q;
				push_grp.b2   = data_byte;
				push_grp.pad  = PAD_NONE;
				push_grp.last = end_of_message;
				push          = take;
			end
			default: begin
				// empty group (position three is treated the same)
				push = take && end_of_message;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 2'd0;
		end else if (take) begin
			if (push) begin
				pos_q <= 2'd0;
			end else if (pos_q == 2'd1) begin
				pos_q <= 2'd2;
			end else begin
				pos_q <= 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && !push) begin
			if (pos_q == 2'd1) begin
				hold1_q <= data_byte;
			end else begin
				hold0_q <= data_byte;
			end
		end
	end

endmodule

### rtl/benc_queue.sv
// Two-entry group queue between front and back.
module benc_queue import benc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  grp_t push_grp,
	output logic full,
	output logic nonempty,
	output grp_t head,
	input  logic pop
);

	localparam int unsigned PW = $clog2(QDEPTH);

	grp_t              mem_q [QDEPTH];
	logic [PW-1:0]     wr_q;
	logic [PW-1:0]     rd_q;
	logic [PW:0]       cnt_q;

	assign full     = (cnt_q == (PW+1)'(QDEPTH));
	assign nonempty = (cnt_q != '0);
	assign head     = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= PW'(wr_q + 1'b1);
			if (pop)  rd_q <= PW'(rd_q + 1'b1);
			case ({push, pop})
				2'b10:   cnt_q <= (PW+1)'(cnt_q + 1'b1);
				2'b01:   cnt_q <= (PW+1)'(cnt_q - 1'b1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_grp;
	end

endmodule

### rtl/benc_back.sv
// Back of the encoder: turns the head group into four characters, one per cycle unless the output stalls.
module benc_back import benc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_nonempty,
	input  grp_t       head,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_char,
	output logic       out_last
);

	slot_t      slot_q;
	logic       valid_q;
	logic [7:0] char_q;
	logic       last_q;
	logic       load;
	logic [5:0] sextet;
	logic [7:0] char_d;
	logic       last_d;

	assign load      = q_nonempty && (!valid_q || out_ready);
	assign pop       = load && (slot_q == SLOT_3);
	assign out_valid = valid_q;
	assign out_char  = char_q;
	assign out_last  = last_q;

	always_comb begin
		unique case (slot_q)
			SLOT_0: sextet = head.b0[7:2];
			SLOT_1: sextet = {head.b0[1:0], head.b1[7:4]};
			SLOT_2: sextet = {head.b1[3:0], head.b2[7:6]};
			SLOT_3: sextet = head.b2[5:0];
			default: sextet = '0;
		endcase
		char_d = sym(sextet);
		if ((slot_q == SLOT_3 && head.pad != PAD_NONE) ||
		    (slot_q == SLOT_2 && head.pad == PAD_TWO)) begin
			char_d = CHAR_PAD;
		end
		last_d = (slot_q == SLOT_3) && head.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			slot_q  <= SLOT_0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				slot_q  <= slot_t'(2'(slot_q + 2'd1));
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			char_q <= char_d;
			last_q <= last_d;
		end
	end

endmodule

### rtl/base64_encoder_unit.sv
// Top level of the streaming base64 encoder (RFC 4648, '=' padding).
//
//  channel  | role | payload                    | transfer when
//  ---------+------+----------------------------+-----------------------
//  in_ch    | sink | data_byte, end_of_message  | valid && ready
//  out_ch   | src  | out_char, out_last         | valid && ready
//
// Each byte is taken on a valid && ready transfer; every closed group (three
// bytes, or a short group at end of message) yields four characters at one
// per cycle, unless the output stalls, from the back end's character
// register, while the queue lets the front take the bytes of later groups.
// Reset is asynchronous and clears group position, queue pointers and the
// output valid; no clearing pass. in_ch.ready drops only while the
// two-entry group queue is full; output stalls hold the character register.
module base64_encoder_unit import benc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	benc_in_if.sink           in_ch,
	benc_out_if.source        out_ch
);

	logic q_push;
	grp_t q_push_grp;
	logic q_full;
	logic q_nonempty;
	grp_t q_head;
	logic q_pop;

	// front: byte collection and group classification
	benc_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_ch.valid),
		.in_ready       (in_ch.ready),
		.data_byte      (in_ch.data_byte),
		.end_of_message (in_ch.end_of_message),
		.push           (q_push),
		.push_grp       (q_push_grp),
		.q_full         (q_full)
	);

	// decoupling queue of closed groups
	benc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_grp (q_push_grp),
		.full     (q_full),
		.nonempty (q_nonempty),
		.head     (q_head),
		.pop      (q_pop)
	);

	// back: character generation and output register
	benc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.head       (q_head),
		.pop        (q_pop),
		.out_valid  (out_ch.valid),
		.out_ready  (out_ch.ready),
		.out_char   (out_ch.out_char),
		.out_last   (out_ch.out_last)
	);

endmodule

### rtl/benc_checker.sv
// Port-level checks of the base64 encoder and their binding to the top level.
`include "base64_encoder_unit_defines.svh"

module benc_checker import benc_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_char,
	input logic       out_last
);

	logic char_ok;
	logic out_xfer;

	assign out_xfer = out_valid && out_ready;
	assign char_ok  = (out_char >= 8'h41 && out_char <= 8'h5A) ||
	                  (out_char >= 8'h61 && out_char <= 8'h7A) ||
	                  (out_char >= 8'h30 && out_char <= 8'h39) ||
	                  (out_char == 8'h2B) || (out_char == 8'h2F) ||
	                  (out_char == CHAR_PAD);

	`BENC_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_last), "stalled output changed")
	`BENC_ASSERT(a_char_legal, clk, arst_n, out_valid |-> char_ok, "output character outside alphabet")
	`BENC_ASSERT(a_pad_run, clk, arst_n, out_xfer && out_char == CHAR_PAD && !out_last |=> out_valid && out_char == CHAR_PAD, "padding not followed by padding")
	`BENC_ASSERT_ALWAYS(a_reset_idle, clk, !arst_n |-> !out_valid, "output valid during reset")

endmodule

bind base64_encoder_unit benc_checker u_benc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_char  (out_ch.out_char),
	.out_last  (out_ch.out_last)
);
